// File: design/hid_boot_report_key_differ_macros.svh
// assertion macros shared by the key differ rtl
`ifndef HID_BOOT_REPORT_KEY_DIFFER_MACROS_SVH
`define HID_BOOT_REPORT_KEY_DIFFER_MACROS_SVH

// same-cycle implication
`define HBRKD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbrkd assertion failed");

// next-cycle implication
`define HBRKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbrkd assertion failed");

`endif

// File: design/hbrkd_pkg.sv
// package: widths, codes and usage-to-action map of the key differ
package hbrkd_pkg;

  localparam int USAGE_W        = 8;
  localparam int ACTION_W       = 5;
  localparam int LEN_W          = 8;
  localparam int FUNC_W         = 2;
  localparam int FIELD_SLOTS    = 6;
  localparam int SLOT_COUNT_DEF = 6;
  localparam int MAX_EVENTS     = 12;
  localparam int CNT_W          = $clog2(MAX_EVENTS + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_REPORT     = 2'd0,
    FUNC_CONNECT    = 2'd1,
    FUNC_DISCONNECT = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RELEASE,
    ST_PRESS,
    ST_FLUSH
  } state_t;

  // 0 means unmapped
  function automatic logic [ACTION_W-1:0] usage_action(input logic [USAGE_W-1:0] u);
    logic [ACTION_W-1:0] a;
    a = '0;
    unique case (u)
      8'h1A, 8'h52: a = 5'd1;
      8'h16, 8'h51: a = 5'd2;
      8'h36, 8'h50: a = 5'd3;
      8'h37, 8'h4F: a = 5'd4;
      8'h04:        a = 5'd5;
      8'h07:        a = 5'd6;
      8'h09:        a = 5'd7;
      8'h2C:        a = 5'd8;
      8'h28:        a = 5'd9;
      8'h29:        a = 5'd10;
      8'h2B:        a = 5'd11;
      default: begin
        if (u >= 8'h1E && u <= 8'h24) begin
          a = 5'd12 + ACTION_W'(u - 8'h1E);
        end
      end
    endcase
    return a;
  endfunction

endpackage

// File: design/hbrkd_if.sv
// valid/ready channels for reports in and key events out
interface hbrkd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] report_length;
  logic [7:0] key_slot_0;
  logic [7:0] key_slot_1;
  logic [7:0] key_slot_2;
  logic [7:0] key_slot_3;
  logic [7:0] key_slot_4;
  logic [7:0] key_slot_5;

  modport source (
    output valid, func, report_length,
    output key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    input  ready
  );
  modport sink (
    input  valid, func, report_length,
    input  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    output ready
  );
endinterface

interface hbrkd_out_if;
  logic       valid;
  logic       ready;
  logic       pressed;
  logic [4:0] action;
  logic [7:0] usage_code;
  logic       last_event;

  modport source (
    output valid, pressed, action, usage_code, last_event,
    input  ready
  );
  modport sink (
    input  valid, pressed, action, usage_code, last_event,
    output ready
  );
endinterface

// File: design/hbrkd_match.sv
// compare unit: one usage against a whole slot set, plus action lookup
module hbrkd_match #(
  parameter int SLOT_COUNT = hbrkd_pkg::SLOT_COUNT_DEF
) (
  input  logic [hbrkd_pkg::USAGE_W-1:0]                 usage,
  input  logic [SLOT_COUNT-1:0][hbrkd_pkg::USAGE_W-1:0] set,
  output logic                                          hit,
  output logic [hbrkd_pkg::ACTION_W-1:0]                action
);
  import hbrkd_pkg::*;

  logic [SLOT_COUNT-1:0] eq;

  always_comb begin
    for (int k = 0; k < SLOT_COUNT; k++) begin
      eq[k] = (set[k] == usage);
    end
  end

  // mapped codes are never zero, so a nonzero action covers the empty check
  assign action = usage_action(usage);
  assign hit    = (action != '0) && !(|eq);

endmodule

// File: design/hid_boot_report_key_differ.sv
// top level: walks prior and new key slots one per cycle, pausing while the event output
// stalls, and emits press/release events; a report or disconnect runs from accept through
// a step per prior slot and a step per new slot to a flush of the held event; connect and
// ignored items do not walk; reset clears the stored slots and all control
// events leave through an output register; a found event is held until the next is found
// or the flush, so that the final one can carry last_event
module hid_boot_report_key_differ #(
  parameter int SLOT_COUNT = hbrkd_pkg::SLOT_COUNT_DEF
) (
  input logic         clk,
  input logic         rst,
  hbrkd_in_if.sink    report,
  hbrkd_out_if.source events
);
  import hbrkd_pkg::*;
  `include "hid_boot_report_key_differ_macros.svh"

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  state_t state, state_next;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] count;
  logic [SLOT_COUNT-1:0][USAGE_W-1:0] prev;
  logic [SLOT_COUNT-1:0][USAGE_W-1:0] now;
  logic [SLOT_COUNT-1:0][USAGE_W-1:0] capture;
  logic [FIELD_SLOTS-1:0][USAGE_W-1:0] field_slots;

  logic                pend_valid;
  logic                pend_pressed;
  logic [ACTION_W-1:0] pend_action;
  logic [USAGE_W-1:0]  pend_usage;

  logic                out_valid;
  logic                out_pressed;
  logic [ACTION_W-1:0] out_action;
  logic [USAGE_W-1:0]  out_usage;
  logic                out_last;

  logic [USAGE_W-1:0]                 cmp_usage;
  logic [SLOT_COUNT-1:0][USAGE_W-1:0] cmp_set;
  logic                               cmp_hit;
  logic [ACTION_W-1:0]                cmp_action;

  logic in_xfer, starts_walk, walking, walk_end, out_free;
  logic step_hit, blocked, push, push_last;

  assign field_slots[0] = report.key_slot_0;
  assign field_slots[1] = report.key_slot_1;
  assign field_slots[2] = report.key_slot_2;
  assign field_slots[3] = report.key_slot_3;
  assign field_slots[4] = report.key_slot_4;
  assign field_slots[5] = report.key_slot_5;

  // slots past the report length or past the six fields read zero; disconnect takes all zero
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_capture
    if (i < FIELD_SLOTS) begin : g_field
      assign capture[i] = (report.func == FUNC_REPORT &&
                           {1'b0, report.report_length} > (LEN_W + 1)'(i + 2))
                          ? field_slots[i] : '0;
    end else begin : g_zero
      assign capture[i] = '0;
    end
  end

  assign report.ready = (state == ST_IDLE);
  assign in_xfer      = report.valid && report.ready;
  assign starts_walk  = (report.func == FUNC_DISCONNECT) ||
                        (report.func == FUNC_REPORT && report.report_length >= 8'd3);

  // shared compare unit: releases test prior slots against new, presses the reverse
  assign cmp_usage = (state == ST_PRESS) ? now[idx] : prev[idx];
  assign cmp_set   = (state == ST_PRESS) ? prev : now;

  hbrkd_match #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_match (
    .usage (cmp_usage),
    .set   (cmp_set),
    .hit   (cmp_hit),
    .action(cmp_action)
  );

  assign walking  = (state == ST_RELEASE) || (state == ST_PRESS);
  assign walk_end = (idx == IDX_W'(SLOT_COUNT - 1));
  assign out_free = !out_valid || events.ready;

  always_comb begin
    step_hit  = walking && cmp_hit && (count < CNT_W'(MAX_EVENTS));
    push      = 1'b0;
    push_last = 1'b0;
    blocked   = 1'b0;
    if (step_hit && pend_valid) begin
      push    = out_free;
      blocked = !out_free;
    end else if (state == ST_FLUSH && pend_valid) begin
      push      = out_free;
      push_last = 1'b1;
      blocked   = !out_free;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && starts_walk) state_next = ST_RELEASE;
      end
      ST_RELEASE: begin
        if (!blocked && walk_end) state_next = ST_PRESS;
      end
      ST_PRESS: begin
        if (!blocked && walk_end) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!blocked) state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      count      <= '0;
      prev       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        idx   <= '0;
        count <= '0;
        if (report.func == FUNC_CONNECT) prev <= '0;
      end
      if (walking && !blocked) begin
        idx <= walk_end ? '0 : idx + 1'b1;
        if (step_hit) begin
          count      <= count + 1'b1;
          pend_valid <= 1'b1;
        end
        if (state == ST_PRESS && walk_end) prev <= now;
      end
      if (state == ST_FLUSH && !blocked) pend_valid <= 1'b0;
      if (push) begin
        out_valid <= 1'b1;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) now <= capture;
    if (walking && !blocked && step_hit) begin
      pend_pressed <= (state == ST_PRESS);
      pend_action  <= cmp_action;
      pend_usage   <= cmp_usage;
    end
    if (push) begin
      out_pressed <= pend_pressed;
      out_action  <= pend_action;
      out_usage   <= pend_usage;
      out_last    <= push_last;
    end
  end

  assign events.valid      = out_valid;
  assign events.pressed    = out_pressed;
  assign events.action     = out_action;
  assign events.usage_code = out_usage;
  assign events.last_event = out_last;

  `HBRKD_ASSERT_NOW(a_idle_no_pend, clk, rst, state == ST_IDLE, !pend_valid)
  `HBRKD_ASSERT_NOW(a_count_cap, clk, rst, 1'b1, count <= CNT_W'(MAX_EVENTS))
  `HBRKD_ASSERT_NEXT(a_disc_clears, clk, rst,
                     in_xfer && report.func == FUNC_DISCONNECT, now == '0)
  `HBRKD_ASSERT_NEXT(a_flush_done, clk, rst,
                     state == ST_FLUSH && !pend_valid, state == ST_IDLE)

endmodule

// File: tb/hid_boot_report_key_differ_test.sv
// self-checking testbench for the hid boot report key differ
`timescale 1ns / 1ps

module hid_boot_report_key_differ_test;
  import hbrkd_pkg::*;

  localparam int SLOT_COUNT     = SLOT_COUNT_DEF;
  localparam int RANDOM_ITEMS   = 75;
  localparam int DRAIN_CYCLES   = 4 * (2 * SLOT_COUNT + 2);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  // func 3 has no meaning and must be ignored
  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE, ACT_FWD, ACT_BACK, ACT_LEFT, ACT_RIGHT, ACT_STRAFE_LEFT, ACT_STRAFE_RIGHT,
    ACT_FIRE, ACT_USE, ACT_ENTER, ACT_ESC, ACT_MAP, ACT_WEAPON_1
  } key_action_t;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [LEN_W-1:0]   length;
    logic [USAGE_W-1:0] keys [FIELD_SLOTS];
  } report_item_t;

  typedef struct packed {
    logic                pressed;
    logic [ACTION_W-1:0] action;
    logic [USAGE_W-1:0]  usage_code;
    logic                last_event;
  } key_event_t;

  class key_event_ledger;
    logic [USAGE_W-1:0] shadow_slots [SLOT_COUNT];
    key_event_t due_events [$];
    int unsigned reports, connects, disconnects, ignored;
    int unsigned checked, presses, releases, mismatches;

    function new();
      shadow_slots = '{default: 8'h00};
    endfunction

    function logic [ACTION_W-1:0] action_of(logic [USAGE_W-1:0] u);
      case (u)
        8'h1A, 8'h52: return ACT_FWD;
        8'h16, 8'h51: return ACT_BACK;
        8'h36, 8'h50: return ACT_LEFT;
        8'h37, 8'h4F: return ACT_RIGHT;
        8'h04:        return ACT_STRAFE_LEFT;
        8'h07:        return ACT_STRAFE_RIGHT;
        8'h09:        return ACT_FIRE;
        8'h2C:        return ACT_USE;
        8'h28:        return ACT_ENTER;
        8'h29:        return ACT_ESC;
        8'h2B:        return ACT_MAP;
        default: begin
          if (u >= 8'h1E && u <= 8'h24) begin
            return ACTION_W'(ACT_WEAPON_1 + (u - 8'h1E));
          end
          return ACT_NONE;
        end
      endcase
    endfunction

    function bit holds(logic [USAGE_W-1:0] slots [SLOT_COUNT], logic [USAGE_W-1:0] u);
      foreach (slots[i]) begin
        if (slots[i] == u) return 1'b1;
      end
      return 1'b0;
    endfunction

    // unmapped usages and anything past the event cap give nothing
    function void add_event(int base, logic pressed, logic [USAGE_W-1:0] u);
      key_event_t e;
      if (action_of(u) == ACT_NONE || due_events.size() - base >= MAX_EVENTS) return;
      e = '{pressed: pressed, action: action_of(u), usage_code: u, last_event: 1'b0};
      due_events.push_back(e);
    endfunction

    function void note_report(report_item_t r);
      logic [USAGE_W-1:0] now [SLOT_COUNT];
      int base;
      int n;
      base = due_events.size();
      if (r.func == FUNC_REPORT && r.length >= 3) begin
        reports++;
        n = int'(r.length) - 2;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          now[i] = (i < FIELD_SLOTS && i < n) ? r.keys[i] : 8'h00;
        end
        // releases first, then presses, each in slot order
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (shadow_slots[i] != 8'h00 && !holds(now, shadow_slots[i])) begin
            add_event(base, 1'b0, shadow_slots[i]);
          end
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (now[i] != 8'h00 && !holds(shadow_slots, now[i])) begin
            add_event(base, 1'b1, now[i]);
          end
        end
        shadow_slots = now;
      end else if (r.func == FUNC_CONNECT) begin
        connects++;
        shadow_slots = '{default: 8'h00};
      end else if (r.func == FUNC_DISCONNECT) begin
        disconnects++;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          add_event(base, 1'b0, shadow_slots[i]);
        end
        shadow_slots = '{default: 8'h00};
      end else begin
        ignored++;
      end
      if (due_events.size() > base) due_events[$].last_event = 1'b1;
    endfunction

    function void check_event(key_event_t got);
      key_event_t want;
      checked++;
      if (got.pressed) presses++;
      else releases++;
      if (due_events.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: event with none due: pressed=%b action=%0d usage=%h last=%b",
                   $realtime, got.pressed, got.action, got.usage_code, got.last_event);
        end
        return;
      end
      want = due_events.pop_front();
      if (got.pressed !== want.pressed || got.action !== want.action ||
          got.usage_code !== want.usage_code || got.last_event !== want.last_event) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: event mismatch: expected pressed=%b action=%0d usage=%h last=%b",
                   $realtime, want.pressed, want.action, want.usage_code, want.last_event);
          $display("%0t:                  actual pressed=%b action=%0d usage=%h last=%b",
                   $realtime, got.pressed, got.action, got.usage_code, got.last_event);
        end
      end
    endfunction
  endclass

  bit clk;
  logic rst = 1'b1;

  hbrkd_in_if  report_ch ();
  hbrkd_out_if events_ch ();

  hid_boot_report_key_differ dut (
    .clk    (clk),
    .rst    (rst),
    .report (report_ch),
    .events (events_ch)
  );

  key_event_ledger ledger = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned quiet_cycles;
  int unsigned TX_IDLE [3] = '{38, 62, 0};
  int unsigned RX_IDLE [3] = '{62, 38, 0};
  logic [USAGE_W-1:0] last_keys [FIELD_SLOTS] = '{default: 8'h00};
  logic [USAGE_W-1:0] mapped_usages [22] = '{
    8'h1A, 8'h52, 8'h16, 8'h51, 8'h36, 8'h50, 8'h37, 8'h4F, 8'h04, 8'h07, 8'h09,
    8'h2C, 8'h28, 8'h29, 8'h2B, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    events_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && events_ch.valid && events_ch.ready) begin
      ledger.check_event('{pressed: events_ch.pressed, action: events_ch.action,
                           usage_code: events_ch.usage_code,
                           last_event: events_ch.last_event});
    end
  end

  // ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (report_ch.valid && report_ch.ready) ||
        (events_ch.valid && events_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles, %0d events still due",
                 WATCHDOG_LIMIT, ledger.due_events.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic report_item_t report_of(logic [FUNC_W-1:0] f, logic [LEN_W-1:0] len,
                                             logic [8*FIELD_SLOTS-1:0] packed_keys);
    report_item_t r;
    r.func   = f;
    r.length = len;
    for (int i = 0; i < FIELD_SLOTS; i++) begin
      r.keys[i] = packed_keys[8*(FIELD_SLOTS-1-i) +: 8];
    end
    return r;
  endfunction

  // mostly full reports built from mapped keys, often reusing keys of the last report
  function automatic report_item_t random_report();
    report_item_t r;
    int unsigned roll;
    roll = $urandom_range(99);
    r.func = (roll < 75) ? FUNC_REPORT : (roll < 87) ? FUNC_DISCONNECT :
             (roll < 95) ? FUNC_CONNECT : FUNC_UNKNOWN;
    roll = $urandom_range(99);
    r.length = (roll < 75) ? 8'd8 : (roll < 88) ? LEN_W'($urandom_range(3, 7)) :
               LEN_W'($urandom_range(0, 255));
    for (int i = 0; i < FIELD_SLOTS; i++) begin
      roll = $urandom_range(99);
      if (roll < 35) r.keys[i] = last_keys[$urandom_range(FIELD_SLOTS - 1)];
      else if (roll < 70) r.keys[i] = mapped_usages[$urandom_range(21)];
      else if (roll < 85) r.keys[i] = 8'h00;
      else r.keys[i] = USAGE_W'($urandom);
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_report(input report_item_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      report_ch.valid <= 1'b0;
      @(negedge clk);
    end
    report_ch.valid         <= 1'b1;
    report_ch.func          <= r.func;
    report_ch.report_length <= r.length;
    report_ch.key_slot_0    <= r.keys[0];
    report_ch.key_slot_1    <= r.keys[1];
    report_ch.key_slot_2    <= r.keys[2];
    report_ch.key_slot_3    <= r.keys[3];
    report_ch.key_slot_4    <= r.keys[4];
    report_ch.key_slot_5    <= r.keys[5];
    do @(posedge clk); while (!report_ch.ready);
    ledger.note_report(r);
    @(negedge clk);
  endtask

  initial begin
    report_item_t directed [$];
    report_item_t r;
    int unsigned random_counted;
    report_ch.valid         = 1'b0;
    report_ch.func          = FUNC_REPORT;
    report_ch.report_length = '0;
    report_ch.key_slot_0    = '0;
    report_ch.key_slot_1    = '0;
    report_ch.key_slot_2    = '0;
    report_ch.key_slot_3    = '0;
    report_ch.key_slot_4    = '0;
    report_ch.key_slot_5    = '0;
    events_ch.ready         = 1'b0;
    random_counted          = 0;

    // short reports, full sets of every action, partial lengths, repeated keys, unknown func, connects and disconnects
    directed.push_back(report_of(FUNC_REPORT,     8'd0,   48'h1A_16_36_37_04_07));
    directed.push_back(report_of(FUNC_REPORT,     8'd2,   48'h1A_16_36_37_04_07));
    directed.push_back(report_of(FUNC_REPORT,     8'd8,   48'h1A_16_36_37_04_07));
    directed.push_back(report_of(FUNC_REPORT,     8'd8,   48'h09_2C_28_29_2B_1E));
    directed.push_back(report_of(FUNC_REPORT,     8'd8,   48'h1F_20_21_22_23_24));
    directed.push_back(report_of(FUNC_REPORT,     8'd8,   48'h52_51_50_4F_00_FF));
    directed.push_back(report_of(FUNC_REPORT,     8'd8,   48'h52_51_50_4F_00_FF));
    directed.push_back(report_of(FUNC_UNKNOWN,    8'd8,   48'h04_07_09_2C_28_29));
    directed.push_back(report_of(FUNC_REPORT,     8'd3,   48'h04_07_09_2C_28_29));
    directed.push_back(report_of(FUNC_REPORT,     8'd5,   48'h04_07_09_2C_28_29));
    directed.push_back(report_of(FUNC_REPORT,     8'd255, 48'h04_04_07_07_80_00));
    directed.push_back(report_of(FUNC_REPORT,     8'd8,   48'h04_00_00_00_00_00));
    directed.push_back(report_of(FUNC_DISCONNECT, 8'd0,   48'h00_00_00_00_00_00));
    directed.push_back(report_of(FUNC_DISCONNECT, 8'd8,   48'h1A_16_36_37_04_07));
    directed.push_back(report_of(FUNC_REPORT,     8'd8,   48'h2B_29_28_FF_80_01));
    directed.push_back(report_of(FUNC_CONNECT,    8'd8,   48'h00_00_00_00_00_00));
    directed.push_back(report_of(FUNC_REPORT,     8'd8,   48'h2B_29_28_00_00_00));
    directed.push_back(report_of(FUNC_REPORT,     8'd1,   48'hFF_FF_FF_FF_FF_FF));
    directed.push_back(report_of(FUNC_REPORT,     8'd8,   48'hFF_FF_FF_FF_FF_FF));
    directed.push_back(report_of(FUNC_DISCONNECT, 8'd255, 48'hFF_FF_FF_FF_FF_FF));
    directed.push_back(report_of(FUNC_REPORT,     8'd7,   48'h1E_1F_20_21_22_23));
    directed.push_back(report_of(FUNC_DISCONNECT, 8'd8,   48'h00_00_00_00_00_00));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = TX_IDLE[p];
      rx_idle_pct = RX_IDLE[p];
      if (p == 0) begin
        foreach (directed[i]) send_report(directed[i]);
      end
      while (random_counted < (p + 1) * RANDOM_ITEMS / 3) begin
        r = random_report();
        if (r.func == FUNC_REPORT) last_keys = r.keys;
        if (r.func == FUNC_CONNECT || r.func == FUNC_DISCONNECT ||
            (r.func == FUNC_REPORT && r.length >= 3)) begin
          random_counted++;
        end
        send_report(r);
      end
    end
    report_ch.valid <= 1'b0;

    while (ledger.due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d reports, %0d connects, %0d disconnects, %0d ignored items",
             ledger.reports, ledger.connects, ledger.disconnects, ledger.ignored);
    $display("checked %0d key events (%0d presses, %0d releases), %0d mismatches",
             ledger.checked, ledger.presses, ledger.releases, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.due_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
